// File: hdl/stp_pkg.sv
package stp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X   = 3'd0,
		REG_ROT_Y   = 3'd1,
		REG_ROT_Z   = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_SCALE_Z = 3'd5,
		REG_SLIDERS = 3'd6
	} cfg_reg_t;

	localparam int COEF_W = 18;
	localparam int PROD_W = 36;
	localparam int ACC_W  = 38;
	localparam int RND_W  = 24;
	localparam int OFF_W  = 15;
	localparam int SCL_W  = 18;
	localparam int POS_W  = 25;
	localparam int DEN_W  = 26;
	localparam int NX_W   = 27;
	localparam int QUO_W  = 15;

	// s1..s11, divider setup, quotient steps, final saturation
	localparam int LANE_LAT = 11 + 1 + QUO_W + 1;

	localparam logic signed [COEF_W-1:0] ONE_Q14 = 18'sd16384;

	// reciprocals for /100 (shift 30) and /50 (shift 25)
	localparam logic [23:0] RECIP_100 = 24'd10737419;
	localparam int          SHIFT_100 = 30;
	localparam logic [19:0] RECIP_50  = 20'd671089;
	localparam int          SHIFT_50  = 25;

	localparam logic [14:0] QSIN [91] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	typedef struct packed {
		logic [2:0][2:0][COEF_W-1:0] mat;
		logic [2:0][OFF_W-1:0]       off;
		logic [2:0][7:0]             pct;
	} xform_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_res_t;

	typedef struct packed {
		logic [15:0] col;
		logic [15:0] row;
		logic        fault;
	} lane_res_t;

	function automatic logic [8:0] wrap_deg(input logic [9:0] a);
		return (a >= 10'd360) ? 9'(a - 10'd360) : a[8:0];
	endfunction

	// a already below 360
	function automatic logic signed [COEF_W-1:0] sine_q14(input logic [8:0] a);
		logic [8:0]  idx;
		logic        neg;
		logic [14:0] mag;
		if (a <= 9'd90) begin
			idx = a;
			neg = 1'b0;
		end else if (a <= 9'd180) begin
			idx = 9'd180 - a;
			neg = 1'b0;
		end else if (a <= 9'd270) begin
			idx = a - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - a;
			neg = 1'b1;
		end
		mag = QSIN[idx[6:0]];
		return neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
	endfunction

	// nearest, ties away from zero
	function automatic logic signed [RND_W-1:0] round_q14(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] q;
		mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		q = (mag + ACC_W'(8192)) >> 14;
		return RND_W'(acc[ACC_W-1] ? (~q + ACC_W'(1)) : q);
	endfunction

endpackage

// File: hdl/stp_cfg.sv
module stp_cfg
	import stp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output xform_t                xf
);

	logic [8:0]  rot_q [3];
	logic [7:0]  pct_q [3];
	logic [23:0] sliders_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				rot_q[i] <= '0;
				pct_q[i] <= 8'd100;
			end
			sliders_q <= 24'd6579300;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROT_X:   rot_q[0]  <= cfg_data[8:0];
				REG_ROT_Y:   rot_q[1]  <= cfg_data[8:0];
				REG_ROT_Z:   rot_q[2]  <= cfg_data[8:0];
				REG_SCALE_X: pct_q[0]  <= cfg_data[7:0];
				REG_SCALE_Y: pct_q[1]  <= cfg_data[7:0];
				REG_SCALE_Z: pct_q[2]  <= cfg_data[7:0];
				REG_SLIDERS: sliders_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [COEF_W-1:0] sn [3];
	logic signed [COEF_W-1:0] cs [3];
	logic signed [COEF_W-1:0] rx [3][3];
	logic signed [COEF_W-1:0] ry [3][3];
	logic signed [COEF_W-1:0] rz [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sn[i] = sine_q14(wrap_deg({1'b0, rot_q[i]}));
			cs[i] = sine_q14(wrap_deg({1'b0, wrap_deg({1'b0, rot_q[i]})} + 10'd90));
		end
		rx[0][0] = ONE_Q14; rx[0][1] = '0;     rx[0][2] = '0;
		rx[1][0] = '0;      rx[1][1] = cs[0];  rx[1][2] = -sn[0];
		rx[2][0] = '0;      rx[2][1] = sn[0];  rx[2][2] = cs[0];
		ry[0][0] = cs[1];   ry[0][1] = '0;     ry[0][2] = sn[1];
		ry[1][0] = '0;      ry[1][1] = ONE_Q14; ry[1][2] = '0;
		ry[2][0] = -sn[1];  ry[2][1] = '0;     ry[2][2] = cs[1];
		rz[0][0] = cs[2];   rz[0][1] = -sn[2]; rz[0][2] = '0;
		rz[1][0] = sn[2];   rz[1][1] = cs[2];  rz[1][2] = '0;
		rz[2][0] = '0;      rz[2][1] = '0;     rz[2][2] = ONE_Q14;
	end

	logic signed [PROD_W-1:0] pxy_s1 [3][3][3];
	logic signed [COEF_W-1:0] rz_s1  [3][3];
	logic signed [COEF_W-1:0] rxy_s2 [3][3];
	logic signed [PROD_W-1:0] pm_s3  [3][3][3];
	logic signed [COEF_W-1:0] mat_s4 [3][3];
	logic signed [ACC_W-1:0]  sxy    [3][3];
	logic signed [ACC_W-1:0]  sm     [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sxy[i][j] = ACC_W'(pxy_s1[i][j][0]) + ACC_W'(pxy_s1[i][j][1])
					+ ACC_W'(pxy_s1[i][j][2]);
				sm[i][j] = ACC_W'(pm_s3[i][j][0]) + ACC_W'(pm_s3[i][j][1])
					+ ACC_W'(pm_s3[i][j][2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pxy_s1[i][j][k] <= PROD_W'(rx[i][k]) * PROD_W'(ry[k][j]);
					pm_s3[i][j][k]  <= PROD_W'(rxy_s2[i][k]) * PROD_W'(rz_s1[k][j]);
				end
				rz_s1[i][j]  <= rz[i][j];
				rxy_s2[i][j] <= COEF_W'(round_q14(sxy[i][j]));
				mat_s4[i][j] <= COEF_W'(round_q14(sm[i][j]));
			end
		end
	end

	// translation offset: round((v - 100) * 4096 / 50)
	logic [40:0]             offp_s1 [3];
	logic                    offn_s1 [3];
	logic signed [OFF_W-1:0] off_s2  [3];
	logic signed [8:0]       sl_k    [3];
	logic [20:0]             sl_mag  [3];
	logic [OFF_W-1:0]        off_q   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sl_k[i]   = $signed({1'b0, sliders_q[8*i +: 8]}) - 9'sd100;
			sl_mag[i] = (sl_k[i][8] ? 21'({-sl_k[i], 12'b0}) : 21'({sl_k[i], 12'b0}))
				+ 21'd25;
			off_q[i]  = OFF_W'(offp_s1[i] >> SHIFT_50);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			offp_s1[i] <= 41'(sl_mag[i]) * 41'(RECIP_50);
			offn_s1[i] <= sl_k[i][8];
			off_s2[i]  <= offn_s1[i] ? -$signed(off_q[i]) : $signed(off_q[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				xf.mat[i][j] = mat_s4[i][j];
			end
			xf.off[i] = off_s2[i];
			xf.pct[i] = pct_q[i];
		end
	end

endmodule

// File: hdl/stp_div.sv
module stp_div
	import stp_pkg::*;
#(
	parameter int NUM_W = 41,
	parameter int DV_W  = 26
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DV_W-1:0]  den,
	output div_res_t                res
);

	localparam int CW = (NUM_W > DV_W + QUO_W) ? NUM_W : DV_W + QUO_W;

	logic [NUM_W-1:0] an;
	logic [DV_W-1:0]  ad;

	assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign ad = den[DV_W-1] ? DV_W'(-den) : DV_W'(den);

	logic [DV_W:0]    rem_s [QUO_W];
	logic [QUO_W-1:0] lo_s  [QUO_W];
	logic [DV_W-1:0]  ad_s  [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (DV_W+1)'(an >> QUO_W);
			lo_s[0]  <= an[QUO_W-1:0];
			ad_s[0]  <= ad;
			quo_s[0] <= '0;
			neg_s[0] <= num[NUM_W-1] ^ den[DV_W-1];
			ovf_s[0] <= CW'(an) >= (CW'(ad) << QUO_W);
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [DV_W+1:0] trial;
		logic [DV_W+1:0] diff;
		logic            fit;

		assign trial = {rem_s[k-1], lo_s[k-1][QUO_W-k]};
		assign diff  = trial - (DV_W+2)'(ad_s[k-1]);
		assign fit   = trial >= (DV_W+2)'(ad_s[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= fit ? (quo_s[k-1] | (QUO_W'(1) << (QUO_W-k))) : quo_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fit ? diff[DV_W:0] : trial[DV_W:0];
					lo_s[k]  <= lo_s[k-1];
					ad_s[k]  <= ad_s[k-1];
				end
			end
		end
	end

	assign res.quo = quo_s[QUO_W];
	assign res.neg = neg_s[QUO_W];
	assign res.ovf = ovf_s[QUO_W];

endmodule

// File: hdl/stp_lane.sv
module stp_lane
	import stp_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  logic signed [15:0] pz,
	input  xform_t             xf,
	output lane_res_t          res
);

	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int HXW    = $clog2(HALF_W + 1);
	localparam int HYW    = $clog2(HALF_H + 1);
	localparam int NUMX_W = NX_W + HXW + 1;
	localparam int NUMY_W = NX_W + HYW + 1;
	localparam logic [HXW-1:0] HALF_W_C = HXW'(HALF_W);
	localparam logic [HYW-1:0] HALF_H_C = HYW'(HALF_H);
	localparam int DIV_LAT = QUO_W + 1;

	logic signed [15:0]       p_s1   [3];
	logic signed [23:0]       n_s2   [3];
	logic [46:0]              sp_s3  [3];
	logic                     sn_s3  [3];
	logic signed [SCL_W-1:0]  s_s4   [3];
	logic signed [SCL_W-1:0]  s_s5   [3];
	logic signed [PROD_W-1:0] pr_s6  [3][3];
	logic signed [ACC_W-1:0]  acc_s7 [3];
	logic signed [RND_W-1:0]  r_s8   [3];
	logic signed [POS_W-1:0]  t_s9   [3];
	logic signed [DEN_W-1:0]  d_s10;
	logic signed [NX_W-1:0]   nx_s10;
	logic signed [NX_W-1:0]   ny_s10;
	logic signed [NUMX_W-1:0] numx_s11;
	logic signed [NUMY_W-1:0] numy_s11;
	logic signed [DEN_W-1:0]  den_s11;
	logic                     flt_s11;
	logic                     flt_d  [DIV_LAT];
	lane_res_t                res_s12;

	logic [22:0]              nmag  [3];
	logic [SCL_W-2:0]         sq    [3];
	logic signed [DEN_W-1:0]  dsum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = (n_s2[i][23] ? 23'(-n_s2[i]) : 23'(n_s2[i])) + 23'd50;
			sq[i]   = sp_s3[i][SHIFT_100 +: SCL_W-1];
		end
		dsum = DEN_W'(t_s9[2]) + DEN_W'(8192);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= px;
			p_s1[1] <= py;
			p_s1[2] <= pz;
			for (int i = 0; i < 3; i++) begin
				n_s2[i]  <= 24'(p_s1[i]) * 24'($signed({1'b0, xf.pct[i]}));
				sp_s3[i] <= 47'(nmag[i]) * 47'(RECIP_100);
				sn_s3[i] <= n_s2[i][23];
				s_s4[i]  <= sn_s3[i] ? -$signed({1'b0, sq[i]}) : $signed({1'b0, sq[i]});
				s_s5[i]  <= s_s4[i];
				for (int j = 0; j < 3; j++) begin
					pr_s6[i][j] <= PROD_W'($signed(xf.mat[i][j])) * PROD_W'(s_s5[j]);
				end
				acc_s7[i] <= ACC_W'(pr_s6[i][0]) + ACC_W'(pr_s6[i][1]) + ACC_W'(pr_s6[i][2]);
				r_s8[i]   <= round_q14(acc_s7[i]);
				t_s9[i]   <= POS_W'(r_s8[i]) + POS_W'($signed(xf.off[i]));
			end
			d_s10    <= dsum;
			nx_s10   <= NX_W'(dsum) + (NX_W'(t_s9[0]) <<< 1);
			ny_s10   <= NX_W'(dsum) - (NX_W'(t_s9[1]) <<< 1);
			numx_s11 <= NUMX_W'(nx_s10) * NUMX_W'($signed({1'b0, HALF_W_C}));
			numy_s11 <= NUMY_W'(ny_s10) * NUMY_W'($signed({1'b0, HALF_H_C}));
			den_s11  <= d_s10;
			flt_s11  <= (d_s10 == '0);
			flt_d[0] <= flt_s11;
			for (int k = 1; k < DIV_LAT; k++) begin
				flt_d[k] <= flt_d[k-1];
			end
		end
	end

	div_res_t qx;
	div_res_t qy;

	stp_div #(.NUM_W(NUMX_W), .DV_W(DEN_W)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s11),
		.den (den_s11),
		.res (qx)
	);

	stp_div #(.NUM_W(NUMY_W), .DV_W(DEN_W)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s11),
		.den (den_s11),
		.res (qy)
	);

	function automatic logic [15:0] coord(input div_res_t q, input logic flt);
		logic [15:0] v;
		if (flt) begin
			v = '0;
		end else if (q.ovf) begin
			v = q.neg ? 16'h8000 : 16'h7FFF;
		end else begin
			v = q.neg ? (16'd0 - {1'b0, q.quo}) : {1'b0, q.quo};
		end
		return v;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res_s12.col   <= coord(qx, flt_d[DIV_LAT-1]);
			res_s12.row   <= coord(qy, flt_d[DIV_LAT-1]);
			res_s12.fault <= flt_d[DIV_LAT-1];
		end
	end

	assign res = res_s12;

endmodule

// File: hdl/segment_transform_project_core.sv
// Wireframe segment transform and perspective projection.
// Input channel (in_valid / in_stall): one segment per request, two Q4.12
// endpoints and a green value. Output channel (out_valid / out_stall): the
// two projected screen points, red/green/blue and a divide fault flag.
// Configuration: cfg_wr_en, cfg_index, cfg_data; write only while no
// request is in flight. Rotation matrix and offsets reach the lanes through
// registers after a write (matrix: pxy_s1, rxy_s2, pm_s3, mat_s4; offsets:
// offp_s1, off_s2). Throughput: one request per clock while in_stall is low.
// Both endpoints run in their own lane, each with a pipelined 15-step
// restoring divider for column and row. Each result passes the 28 lane
// stages, the first loaded at the accepting edge, then the output register.
// Reset clears the configuration to identity rotation, unit scale and zero
// offset, and empties the pipeline and output registers.
// When out_stall holds a result, the next one is parked in a skid register
// and the pipeline keeps running; in_stall rises only once that register
// is full, and the pipeline then holds until the output is taken.
module segment_transform_project_core
	import stp_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    begin_x,
	input  logic signed [15:0]    begin_y,
	input  logic signed [15:0]    begin_z,
	input  logic signed [15:0]    end_x,
	input  logic signed [15:0]    end_y,
	input  logic signed [15:0]    end_z,
	input  logic [7:0]            green_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    start_screen_x,
	output logic signed [15:0]    start_screen_y,
	output logic signed [15:0]    end_screen_x,
	output logic signed [15:0]    end_screen_y,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic                  divide_fault
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	typedef struct packed {
		lane_res_t b;
		lane_res_t e;
		colour_t   c;
	} result_t;

	xform_t xf;
	logic   en;
	logic   skid_valid_q;
	logic   out_valid_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	stp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.xf        (xf)
	);

	lane_res_t res_b;
	lane_res_t res_e;

	stp_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_lane_b (
		.clk (clk),
		.en  (en),
		.px  (begin_x),
		.py  (begin_y),
		.pz  (begin_z),
		.xf  (xf),
		.res (res_b)
	);

	stp_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_lane_e (
		.clk (clk),
		.en  (en),
		.px  (end_x),
		.py  (end_y),
		.pz  (end_z),
		.xf  (xf),
		.res (res_e)
	);

	// red/blue = trunc((4064 +/- y) / 32), clamped to 0..255
	logic signed [16:0] rsum;
	logic signed [16:0] bsum;
	colour_t            cin;

	always_comb begin
		rsum = 17'sd4064 + 17'(begin_y);
		bsum = 17'sd4064 - 17'(begin_y);
		cin.green = green_in;
		if (rsum[16])
			cin.red = '0;
		else if (rsum[15:5] > 11'd255)
			cin.red = 8'hFF;
		else
			cin.red = rsum[12:5];
		if (bsum[16])
			cin.blue = '0;
		else if (bsum[15:5] > 11'd255)
			cin.blue = 8'hFF;
		else
			cin.blue = bsum[12:5];
	end

	logic    vld_s [LANE_LAT];
	colour_t col_s [LANE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LANE_LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s[0] <= cin;
			for (int k = 1; k < LANE_LAT; k++)
				col_s[k] <= col_s[k-1];
		end
	end

	result_t tail;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    push;

	assign tail.b = res_b;
	assign tail.e = res_e;
	assign tail.c = col_s[LANE_LAT-1];
	assign take   = out_valid_q && !out_stall;
	assign push   = vld_s[LANE_LAT-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take)
			out_q <= skid_valid_q ? skid_q : tail;
		else if (push)
			skid_q <= tail;
	end

	assign out_valid      = out_valid_q;
	assign start_screen_x = out_q.b.col;
	assign start_screen_y = out_q.b.row;
	assign end_screen_x   = out_q.e.col;
	assign end_screen_y   = out_q.e.row;
	assign red_out        = out_q.c.red;
	assign green_out      = out_q.c.green;
	assign blue_out       = out_q.c.blue;
	assign divide_fault   = out_q.b.fault | out_q.e.fault;

endmodule

// File: test/segment_transform_project_core_tb.sv
module segment_transform_project_core_tb;
	import stp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  HALF_W       = 1024 / 2;
	localparam int  HALF_H       = 768 / 2;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  CYCLE_LIMIT  = 600000;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 3'd7;

	typedef longint mat3_t [3][3];

	typedef struct {
		logic signed [15:0] sx, sy, ex, ey;
		logic [7:0]         r, g, b;
		logic               f;
	} screen_seg_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [15:0] begin_x, begin_y, begin_z, end_x, end_y, end_z;
	logic [7:0] green_in;
	logic signed [15:0] start_screen_x, start_screen_y, end_screen_x, end_screen_y;
	logic [7:0] red_out, green_out, blue_out;
	logic divide_fault;

	segment_transform_project_core u_dut (.*);

	// register copies and derived transform
	int     rot_deg [3];
	int     scale_pct [3];
	int     sliders;
	mat3_t  xf_mat;
	longint xf_off [3];

	screen_seg_t pending_segs [$];
	int  errors, accepted, checked, faults_seen;
	int  cycles;
	bit  stall_on, gaps_on;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic longint div_nearest(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint sin_q14(int deg);
		int a;
		longint mag;
		real rad;
		a = deg % 360;
		if (a > 90 && a <= 180) a = 180 - a;
		else if (a > 180 && a <= 270) a = a - 180;
		else if (a > 270) a = 360 - a;
		rad = a * 3.141592653589793 / 180.0;
		mag = longint'($floor(16384.0 * $sin(rad) + 0.5));
		return ((deg % 360) > 180) ? -mag : mag;
	endfunction

	function automatic longint cos_q14(int deg);
		return sin_q14((deg % 360) + 90);
	endfunction

	function automatic mat3_t mat_product(mat3_t a, mat3_t b);
		mat3_t r;
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += a[i][k] * b[k][j];
				r[i][j] = div_nearest(acc, 16384);
			end
		return r;
	endfunction

	function automatic void refresh_xform();
		mat3_t rx, ry, rz;
		longint cx, sx, cy, sy, cz, sz;
		cx = cos_q14(rot_deg[0]); sx = sin_q14(rot_deg[0]);
		cy = cos_q14(rot_deg[1]); sy = sin_q14(rot_deg[1]);
		cz = cos_q14(rot_deg[2]); sz = sin_q14(rot_deg[2]);
		rx = '{'{16384, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
		ry = '{'{cy, 0, sy}, '{0, 16384, 0}, '{-sy, 0, cy}};
		rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, 16384}};
		xf_mat = mat_product(mat_product(rx, ry), rz);
		for (int i = 0; i < 3; i++)
			xf_off[i] = div_nearest((longint'((sliders >> (8 * i)) & 8'hFF) - 100) * 4096, 50);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [7:0] clamp8(longint v);
		if (v > 255) return 8'd255;
		if (v < 0) return 8'd0;
		return v[7:0];
	endfunction

	function automatic bit map_endpoint(input longint p [3], output logic signed [15:0] col,
			output logic signed [15:0] row);
		longint s [3], t [3];
		longint d;
		for (int i = 0; i < 3; i++)
			s[i] = div_nearest(p[i] * scale_pct[i], 100);
		for (int i = 0; i < 3; i++)
			t[i] = div_nearest(xf_mat[i][0] * s[0] + xf_mat[i][1] * s[1]
				+ xf_mat[i][2] * s[2], 16384) + xf_off[i];
		d = t[2] + 8192;
		if (d == 0) begin
			col = '0;
			row = '0;
			return 1'b1;
		end
		col = clamp16((HALF_W * (d + 2 * t[0])) / d);
		row = clamp16((HALF_H * (d - 2 * t[1])) / d);
		return 1'b0;
	endfunction

	function automatic screen_seg_t project_segment(logic signed [15:0] bx, by, bz, ex, ey,
			ez, logic [7:0] g);
		screen_seg_t r;
		bit f0, f1;
		f0 = map_endpoint('{bx, by, bz}, r.sx, r.sy);
		f1 = map_endpoint('{ex, ey, ez}, r.ex, r.ey);
		r.f = f0 | f1;
		r.r = clamp8((4064 + longint'(by)) / 32);
		r.b = clamp8((4064 - longint'(by)) / 32);
		r.g = g;
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_ROT_X:   rot_deg[0] = val[8:0];
			REG_ROT_Y:   rot_deg[1] = val[8:0];
			REG_ROT_Z:   rot_deg[2] = val[8:0];
			REG_SCALE_X: scale_pct[0] = val[7:0];
			REG_SCALE_Y: scale_pct[1] = val[7:0];
			REG_SCALE_Z: scale_pct[2] = val[7:0];
			REG_SLIDERS: sliders = val;
			default: ;
		endcase
		refresh_xform();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_all(int ax, ay, az, px, py, pz, int sl);
		drain();
		write_reg(REG_ROT_X, CFG_DATA_W'(ax));
		write_reg(REG_ROT_Y, CFG_DATA_W'(ay));
		write_reg(REG_ROT_Z, CFG_DATA_W'(az));
		write_reg(REG_SCALE_X, CFG_DATA_W'(px));
		write_reg(REG_SCALE_Y, CFG_DATA_W'(py));
		write_reg(REG_SCALE_Z, CFG_DATA_W'(pz));
		write_reg(REG_SLIDERS, CFG_DATA_W'(sl));
		repeat (5) @(posedge clk);
	endtask

	// leaves valid high; the next send or a gap decides what follows
	task automatic send_segment(logic signed [15:0] bx, by, bz, ex, ey, ez, logic [7:0] g);
		int gap;
		in_valid <= 1'b1;
		begin_x <= bx; begin_y <= by; begin_z <= bz;
		end_x <= ex; end_y <= ey; end_z <= ez;
		green_in <= g;
		do @(posedge clk); while (in_stall);
		pending_segs = {pending_segs, project_segment(bx, by, bz, ex, ey, ez, g)};
		accepted++;
		if (gaps_on) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
				: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
			2: return $signed(16'($urandom_range(0, 1024))) - 16'sd512;
			default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	task automatic send_random();
		send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), 8'($urandom));
	endtask

	// output side stall pattern
	int stall_left;
	always @(posedge clk) begin
		if (!stall_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					stall_left <= $urandom_range(10, 40);
					out_stall <= 1'b1;
				end
				1, 2, 3, 4, 5: begin
					stall_left <= $urandom_range(0, 2);
					out_stall <= 1'b1;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		screen_seg_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_segs.size() == 0) begin
				$display("%0t: unexpected result, expected none, got col %0d", $time,
					start_screen_x);
				errors++;
			end else begin
				w = pending_segs.pop_front();
				check_field("start_screen_x", w.sx, start_screen_x);
				check_field("start_screen_y", w.sy, start_screen_y);
				check_field("end_screen_x", w.ex, end_screen_x);
				check_field("end_screen_y", w.ey, end_screen_y);
				check_field("red_out", w.r, red_out);
				check_field("green_out", w.g, green_out);
				check_field("blue_out", w.b, blue_out);
				check_field("divide_fault", w.f, divide_fault);
				faults_seen += w.f;
				checked++;
			end
		end
	end

	task automatic test_reset_identity();
		stall_on = 0;
		gaps_on  = 0;
		send_segment(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 8'hFF);
		send_segment(0, 0, 0, 0, 0, 0, 8'h00);
		send_segment(4096, -4096, 4096, -4096, 4096, -4096, 8'hA5);
		send_segment(0, 4064, 0, 0, 0, 0, 8'h5A);
		send_segment(0, -4064, 0, 0, 0, 0, 8'h01);
		send_segment(0, 31, 0, 0, 0, 0, 8'h80);
		send_segment(0, -33, 0, 0, 0, 0, 8'h7F);
	endtask

	task automatic test_zero_depth();
		// z+2 lands on zero at one endpoint, then the other, then both
		stall_on = 1;
		gaps_on  = 1;
		send_segment(100, 200, -8192, 300, 400, 500, 8'h11);
		send_segment(100, 200, 500, 300, 400, -8192, 8'h22);
		send_segment(0, 0, -8192, 0, 0, -8192, 8'h33);
		send_segment(0, 0, -8191, 0, 0, -8193, 8'h44);
	endtask

	task automatic test_register_extremes();
		set_all(90, 0, 0, 100, 100, 100, 32'h646464);
		send_segment(4096, 4096, 4096, -4096, 2048, 1024, 8'h10);
		set_all(360, 511, 270, 0, 255, 1, 32'hFFFFFF);
		send_segment(16'sh7FFF, 16'sh8000, 4096, 1000, -1000, 16'sh7FFF, 8'h20);
		send_segment(4096, 4096, 4096, -4096, -4096, -4096, 8'h30);
		set_all(180, 359, 45, 200, 1, 200, 0);
		send_segment(4096, 4096, 4096, 16'sh8000, 16'sh7FFF, -2048, 8'h40);
		set_all(1, 91, 181, 255, 200, 0, 32'hC8C8C8);
		send_segment(2000, -3000, 4096, -1, 1, 16'sh8000, 8'h50);
		// write to a register that does not exist leaves everything as it is
		drain();
		write_reg(SPARE_IDX, 24'hFFFFFF);
		repeat (5) @(posedge clk);
		send_segment(2000, -3000, 4096, -1, 1, 16'sh8000, 8'h60);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 12; ph++) begin
			set_all($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
				$urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 200),
				$urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 200),
				$urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 200),
				$urandom_range(0, 3) == 0 ? $urandom & 24'hFFFFFF
					: {8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
						8'($urandom_range(0, 200))});
			stall_on = (ph % 4) != 1;
			gaps_on  = (ph % 4) != 2;
			for (int n = 0; n < 52; n++)
				send_random();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		begin_x <= '0; begin_y <= '0; begin_z <= '0;
		end_x <= '0; end_y <= '0; end_z <= '0;
		green_in <= '0;
		out_stall <= 1'b0;
		cycles = 0;
		errors = 0;
		rot_deg   = '{0, 0, 0};
		scale_pct = '{100, 100, 100};
		sliders   = 24'h646464;
		refresh_xform();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_identity();
		test_zero_depth();
		test_register_extremes();
		test_random_phases();
		drain();

		$display("Checked %0d segments of %0d sent, %0d with a zero depth fault,",
			checked, accepted, faults_seen);
		$display("over identity, extreme and random rotation, scale and offset settings.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
hdl/stp_pkg.sv
hdl/stp_cfg.sv
hdl/stp_div.sv
hdl/stp_lane.sv
hdl/segment_transform_project_core.sv
test/segment_transform_project_core_tb.sv
